// File: design/inorder_completion_tracker_core_defines.svh
// Assertion macros used by the in-order completion tracker controller.
`ifndef INORDER_COMPLETION_TRACKER_CORE_DEFINES_SVH
`define INORDER_COMPLETION_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ICT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ICT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ict_pkg.sv
// Shared constants, codes and types of the in-order completion tracker.
package ict_pkg;

    // Capacity of the record chain and derived widths.
    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SEQ_W  = 32;
    localparam int TAG_W  = 16;
    localparam int OP_W   = 2;
    localparam int KIND_W = 3;

    // Command opcodes.
    localparam logic [OP_W-1:0] OP_ISSUE    = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH    = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ISSUED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WINDOW   = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RETIRE
    } state_t;

    // One stored write record.
    typedef struct packed {
        logic             active;
        logic             lfb;
        logic [TAG_W-1:0] tag;
    } rec_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic             shift;
        logic             issue_we;
        logic             mark_en;
        logic             scan_load;
        logic             scan_shift;
        logic [CNT_W-1:0] wr_pos;
        logic [CNT_W-1:0] mark_lo;
        logic [CNT_W-1:0] mark_hi;
        logic [TAG_W-1:0] tag;
        logic             lfb;
    } cell_ctrl_t;

endpackage

// File: design/ict_cmd_if.sv
// Command channel interface of the completion tracker.
interface ict_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [ict_pkg::OP_W-1:0]    opcode;
    logic [ict_pkg::TAG_W-1:0]   block_tag;
    logic                        last_for_block;
    logic [ict_pkg::SEQ_W-1:0]   range_begin;
    logic [ict_pkg::SEQ_W-1:0]   range_end;

    modport source (
        output valid, opcode, block_tag, last_for_block, range_begin, range_end,
        input  ready
    );

    modport sink (
        input  valid, opcode, block_tag, last_for_block, range_begin, range_end,
        output ready
    );
endinterface

// File: design/ict_res_if.sv
// Result channel interface of the completion tracker.
interface ict_res_if;
    logic                        valid;
    logic                        ready;
    logic [ict_pkg::KIND_W-1:0]  kind;
    logic [ict_pkg::SEQ_W-1:0]   sequence_res;
    logic [ict_pkg::TAG_W-1:0]   released_tag;
    logic [ict_pkg::CNT_W-1:0]   outstanding;
    logic                        last;

    modport source (
        output valid, kind, sequence_res, released_tag, outstanding, last,
        input  ready
    );

    modport sink (
        input  valid, kind, sequence_res, released_tag, outstanding, last,
        output ready
    );
endinterface

// File: design/ict_cell.sv
// One cell of the record chain: holds the record at a fixed offset from the head.
module ict_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ict_pkg::IDX_W-1:0]   idx,
    input  ict_pkg::cell_ctrl_t         ctrl,
    input  ict_pkg::rec_t               up_rec,
    input  logic                        up_scan,
    output ict_pkg::rec_t               rec,
    output logic                        scan
);

    logic                        active_reg;
    logic                        active_next;
    logic                        lfb_reg;
    logic                        lfb_next;
    logic [ict_pkg::TAG_W-1:0]   tag_reg;
    logic [ict_pkg::TAG_W-1:0]   tag_next;
    logic                        scan_reg;
    logic                        scan_next;
    logic [ict_pkg::CNT_W-1:0]   pos;
    logic                        hit_wr;
    logic                        hit_mark;
    logic                        marked_active;

    // Offset of this cell from the head, compared against the broadcast positions.
    assign pos      = ict_pkg::CNT_W'(idx);
    assign hit_wr   = ctrl.issue_we && (pos == ctrl.wr_pos);
    assign hit_mark = ctrl.mark_en && (pos >= ctrl.mark_lo) && (pos <= ctrl.mark_hi);
    assign marked_active = active_reg && !hit_mark;

    // Record update: shift toward the head on retire, write on issue, clear on completion.
    always_comb
    begin
        active_next = active_reg;
        lfb_next    = lfb_reg;
        tag_next    = tag_reg;
        if (ctrl.shift)
        begin
            active_next = up_rec.active;
            lfb_next    = up_rec.lfb;
            tag_next    = up_rec.tag;
        end
        else if (hit_wr)
        begin
            active_next = 1'b1;
            lfb_next    = ctrl.lfb;
            tag_next    = ctrl.tag;
        end
        else if (ctrl.mark_en)
        begin
            active_next = marked_active;
        end
    end

    // Scan bit: a copy of the post-completion marks that walks toward the head.
    always_comb
    begin
        scan_next = scan_reg;
        if (ctrl.scan_load)
        begin
            scan_next = marked_active;
        end
        else if (ctrl.scan_shift)
        begin
            scan_next = up_scan;
        end
    end

    // Control state of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            scan_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            scan_reg   <= scan_next;
        end
    end

    // Payload of the cell, undefined until written.
    always_ff @(posedge clk)
    begin
        lfb_reg <= lfb_next;
        tag_reg <= tag_next;
    end

    assign rec.active = active_reg;
    assign rec.lfb    = lfb_reg;
    assign rec.tag    = tag_reg;
    assign scan       = scan_reg;

endmodule

// File: design/ict_ctrl.sv
// Controller of the completion tracker: sequencing, head and count, result register.
`include "inorder_completion_tracker_core_defines.svh"

module ict_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    ict_cmd_if.sink               cmd,
    ict_res_if.source             res,
    input  ict_pkg::rec_t         head_rec,
    input  logic                  head_scan,
    output ict_pkg::cell_ctrl_t   cell_ctrl
);

    ict_pkg::state_t               state_reg, state_next;
    logic [ict_pkg::SEQ_W-1:0]     head_reg, head_next;
    logic [ict_pkg::CNT_W-1:0]     held_reg, held_next;
    logic [ict_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ict_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [ict_pkg::CNT_W-1:0]     outst_reg, outst_next;

    // Latched command.
    logic [ict_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ict_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic                          lfb_reg, lfb_next;
    logic [ict_pkg::SEQ_W-1:0]     rb_reg, rb_next;
    logic [ict_pkg::SEQ_W-1:0]     ob_reg, ob_next;
    logic [ict_pkg::SEQ_W-1:0]     oe_reg, oe_next;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    logic [ict_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [ict_pkg::SEQ_W-1:0]     seq_reg, seq_next;
    logic [ict_pkg::TAG_W-1:0]     rtag_reg, rtag_next;
    logic [ict_pkg::CNT_W-1:0]     ocnt_reg, ocnt_next;
    logic                          last_reg, last_next;

    // Result about to be loaded.
    logic                          emit;
    logic [ict_pkg::KIND_W-1:0]    emit_kind;
    logic [ict_pkg::SEQ_W-1:0]     emit_seq;
    logic [ict_pkg::TAG_W-1:0]     emit_tag;
    logic [ict_pkg::CNT_W-1:0]     emit_ocnt;
    logic                          emit_last;

    logic                          out_free;
    logic [ict_pkg::SEQ_W-1:0]     seq_tail;
    logic                          reject;
    logic                          full;

    assign out_free = !out_valid_reg || res.ready;
    assign seq_tail = head_reg + ict_pkg::SEQ_W'(held_reg);
    assign full     = (held_reg == ict_pkg::CNT_W'(ict_pkg::DEPTH));

    // Window check of a completion range, on offsets from the head.
    assign reject = (held_reg == '0)
                 || (ob_reg >= ict_pkg::SEQ_W'(held_reg))
                 || (oe_reg >= ict_pkg::SEQ_W'(held_reg))
                 || (ob_reg > oe_reg);

    // Next state, cell control and result generation.
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        outst_next = outst_reg;
        op_next    = op_reg;
        tag_next   = tag_reg;
        lfb_next   = lfb_reg;
        rb_next    = rb_reg;
        ob_next    = ob_reg;
        oe_next    = oe_reg;

        emit      = 1'b0;
        emit_kind = ict_pkg::KIND_ISSUED;
        emit_seq  = seq_tail;
        emit_tag  = '0;
        emit_ocnt = held_reg;
        emit_last = 1'b1;

        cell_ctrl         = '0;
        cell_ctrl.wr_pos  = held_reg;
        cell_ctrl.mark_lo = ob_reg[ict_pkg::CNT_W-1:0];
        cell_ctrl.mark_hi = oe_reg[ict_pkg::CNT_W-1:0];
        cell_ctrl.tag     = tag_reg;
        cell_ctrl.lfb     = lfb_reg;

        case (state_reg)
            ict_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.opcode;
                    tag_next   = cmd.block_tag;
                    lfb_next   = cmd.last_for_block;
                    rb_next    = cmd.range_begin;
                    ob_next    = cmd.range_begin - head_reg;
                    oe_next    = cmd.range_end - head_reg;
                    state_next = ict_pkg::S_DECODE;
                end
            end

            ict_pkg::S_DECODE:
            begin
                case (op_reg)
                    ict_pkg::OP_ISSUE:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_kind = ict_pkg::KIND_FULL;
                            end
                            else
                            begin
                                cell_ctrl.issue_we = 1'b1;
                                held_next = held_reg + ict_pkg::CNT_W'(1);
                                emit_ocnt = held_reg + ict_pkg::CNT_W'(1);
                            end
                            state_next = ict_pkg::S_IDLE;
                        end
                    end
                    ict_pkg::OP_COMPLETE:
                    begin
                        if (reject)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                emit_kind  = ict_pkg::KIND_WINDOW;
                                emit_seq   = rb_reg;
                                state_next = ict_pkg::S_IDLE;
                            end
                        end
                        else
                        begin
                            cell_ctrl.mark_en   = 1'b1;
                            cell_ctrl.scan_load = 1'b1;
                            cnt_next   = '0;
                            state_next = ict_pkg::S_SCAN;
                        end
                    end
                    ict_pkg::OP_FLUSH:
                    begin
                        if (held_reg == '0)
                        begin
                            state_next = ict_pkg::S_IDLE;
                        end
                        else
                        begin
                            rem_next   = held_reg;
                            outst_next = '0;
                            state_next = ict_pkg::S_RETIRE;
                        end
                    end
                    default:
                    begin
                        state_next = ict_pkg::S_IDLE;
                    end
                endcase
            end

            // Count the inactive records at the head, one cell per cycle.
            ict_pkg::S_SCAN:
            begin
                if ((cnt_reg == held_reg) || head_scan)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = ict_pkg::S_IDLE;
                    end
                    else
                    begin
                        rem_next   = cnt_reg;
                        outst_next = held_reg - cnt_reg;
                        state_next = ict_pkg::S_RETIRE;
                    end
                end
                else
                begin
                    cell_ctrl.scan_shift = 1'b1;
                    cnt_next = cnt_reg + ict_pkg::CNT_W'(1);
                end
            end

            // Retire the head record, one per free output slot.
            ict_pkg::S_RETIRE:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_kind = head_rec.lfb ? ict_pkg::KIND_RELEASED : ict_pkg::KIND_DONE;
                    emit_seq  = head_reg;
                    emit_tag  = head_rec.lfb ? head_rec.tag : '0;
                    emit_ocnt = outst_reg;
                    emit_last = (rem_reg == ict_pkg::CNT_W'(1));
                    cell_ctrl.shift = 1'b1;
                    head_next = head_reg + ict_pkg::SEQ_W'(1);
                    held_next = held_reg - ict_pkg::CNT_W'(1);
                    rem_next  = rem_reg - ict_pkg::CNT_W'(1);
                    if (rem_reg == ict_pkg::CNT_W'(1))
                    begin
                        state_next = ict_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ict_pkg::S_IDLE;
            end
        endcase

        // Result register load or drain.
        out_valid_next = out_valid_reg && !res.ready;
        kind_next      = kind_reg;
        seq_next       = seq_reg;
        rtag_next      = rtag_reg;
        ocnt_next      = ocnt_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            seq_next       = emit_seq;
            rtag_next      = emit_tag;
            ocnt_next      = emit_ocnt;
            last_next      = emit_last;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ict_pkg::S_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            outst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            outst_reg     <= outst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        lfb_reg  <= lfb_next;
        rb_reg   <= rb_next;
        ob_reg   <= ob_next;
        oe_reg   <= oe_next;
        kind_reg <= kind_next;
        seq_reg  <= seq_next;
        rtag_reg <= rtag_next;
        ocnt_reg <= ocnt_next;
        last_reg <= last_next;
    end

    assign cmd.ready        = (state_reg == ict_pkg::S_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.kind         = kind_reg;
    assign res.sequence_res = seq_reg;
    assign res.released_tag = rtag_reg;
    assign res.outstanding  = ocnt_reg;
    assign res.last         = last_reg;

    // The record count never exceeds the chain capacity.
    `ICT_ASSERT_NOW(a_held_bound, 1'b1, held_reg <= ict_pkg::CNT_W'(ict_pkg::DEPTH), "record count exceeds capacity")

    // Retiring always has records left to retire, and no more than are held.
    `ICT_ASSERT_NOW(a_retire_rem, state_reg == ict_pkg::S_RETIRE, (rem_reg != '0) && (rem_reg <= held_reg), "retire count out of range")

    // The final retire of an item leaves exactly the count reported in its results.
    `ICT_ASSERT_NEXT(a_retire_end, (state_reg == ict_pkg::S_RETIRE) && out_free && (rem_reg == ict_pkg::CNT_W'(1)), (state_reg == ict_pkg::S_IDLE) && (held_reg == ocnt_reg) && res.valid && res.last, "final retire count mismatch")

    // The scan never runs past the held records.
    `ICT_ASSERT_NOW(a_scan_bound, state_reg == ict_pkg::S_SCAN, cnt_reg <= held_reg, "scan ran past held records")

endmodule

// File: design/inorder_completion_tracker_core.sv
// The tracker takes one transaction at a time: a command is accepted only in the idle state.
// An issue or a rejected completion is decoded and then loads its result once the result
// register is free; a completion scans the head cells one per cycle and then retires the
// inactive head records, and a flush retires every held record, one per free output slot.
// A stall on the result channel holds the decode result and each retire.
// Reset clears the active marks, head sequence and record count; tags are not reset.
module inorder_completion_tracker_core (
    input  logic        clk,
    input  logic        rst_n,
    ict_cmd_if.sink     cmd,
    ict_res_if.source   res
);

    ict_pkg::rec_t        rec  [ict_pkg::DEPTH];
    logic                 scan [ict_pkg::DEPTH];
    ict_pkg::cell_ctrl_t  cell_ctrl;

    // Chain of record cells; cell 0 holds the head record.
    for (genvar i = 0; i < ict_pkg::DEPTH; i++)
    begin : g_cell
        ict_pkg::rec_t up_rec;
        logic          up_scan;

        if (i == ict_pkg::DEPTH - 1)
        begin : g_top
            assign up_rec  = '0;
            assign up_scan = 1'b0;
        end
        else
        begin : g_mid
            assign up_rec  = rec[i + 1];
            assign up_scan = scan[i + 1];
        end

        ict_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (ict_pkg::IDX_W'(i)),
            .ctrl    (cell_ctrl),
            .up_rec  (up_rec),
            .up_scan (up_scan),
            .rec     (rec[i]),
            .scan    (scan[i])
        );
    end

    // Sequencing, head tracking and result register.
    ict_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .head_rec  (rec[0]),
        .head_scan (scan[0]),
        .cell_ctrl (cell_ctrl)
    );

endmodule
